/* rtl/sal_pkg.sv */
package sal_pkg;

  localparam int FUNC_W = 2;
  localparam int SYM_W  = 8;
  localparam int IDX_W  = 11;
  localparam int STS_W  = 2;
  localparam int LCP_W  = 10;
  localparam int ALIM_W = 9;

  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STS_W-1:0] STS_BAD_SYM = 2'd2;
  localparam logic [STS_W-1:0] STS_BAD_IDX = 2'd3;

  localparam logic [ALIM_W-1:0] ALIM_RESET = 9'd256;
  localparam logic              REG_ALIM   = 1'b0;

  typedef enum logic [33:0] {
    OP_IDLE    = 34'd1 << 0,
    OP_RDWAIT  = 34'd1 << 1,
    OP_INIT_RD = 34'd1 << 2,
    OP_INIT_WR = 34'd1 << 3,
    OP_YA      = 34'd1 << 4,
    OP_YB_RD   = 34'd1 << 5,
    OP_YB_WR   = 34'd1 << 6,
    OP_CLR     = 34'd1 << 7,
    OP_H_RDX   = 34'd1 << 8,
    OP_H_RDC   = 34'd1 << 9,
    OP_H_WR    = 34'd1 << 10,
    OP_P_RD    = 34'd1 << 11,
    OP_P_WR    = 34'd1 << 12,
    OP_S_RDY   = 34'd1 << 13,
    OP_S_RDX   = 34'd1 << 14,
    OP_S_RDC   = 34'd1 << 15,
    OP_S_WR    = 34'd1 << 16,
    OP_R_RD0   = 34'd1 << 17,
    OP_R_WR0   = 34'd1 << 18,
    OP_C_RDS   = 34'd1 << 19,
    OP_C_RDA   = 34'd1 << 20,
    OP_C_RDB   = 34'd1 << 21,
    OP_C_RDAJ  = 34'd1 << 22,
    OP_C_RDBJ  = 34'd1 << 23,
    OP_C_WR    = 34'd1 << 24,
    OP_F_RD    = 34'd1 << 25,
    OP_F_WR    = 34'd1 << 26,
    OP_L_START = 34'd1 << 27,
    OP_L_RDR   = 34'd1 << 28,
    OP_L_RDS   = 34'd1 << 29,
    OP_L_RDT1  = 34'd1 << 30,
    OP_L_RDT2  = 34'd1 << 31,
    OP_L_CMP   = 34'd1 << 32,
    OP_DONE    = 34'd1 << 33
  } sal_op_t;

  typedef struct packed {
    sal_op_t op;
    logic    in_ready;
  } sal_cmd_t;

  typedef struct packed {
    logic i_lt_n;
    logic i_lt_j;
    logic i_last_ts;
    logic i_zero;
    logic p_eq_n;
    logic rank_zero;
    logic match;
    logic i1_lt_n;
    logic rd_go;
    logic build_go;
    logic out_free;
  } sal_stat_t;

endpackage

/* rtl/suffix_array_lcp_builder.sv */
// Suffix array and LCP builder.
// Input stream (in_*): one item per command: append a symbol, build, or read
// one sorted entry. Output stream (out_*): exactly one result item per input
// item, in order. An APB register at address 0 holds the alphabet limit.
// Append, rejected read and unused command: the result is registered as
// the item is taken, so appends run at one item per cycle while the receiver
// keeps up. Good read: the suffix and LCP stores are read into registers,
// then the wait state loads the result into the output register.
// Build: a sequencer walks single-port stores through up to ceil(log2 n) + 1
// prefix-doubling rounds (n = text length + 1), each with a counting sort
// over a table of at least 256 entries, then a final-rank pass and an LCP
// pass.
// One item is in work at a time; in_tready is high only when the sequencer
// is idle and the output register is empty or being drained, so a stalled
// receiver holds the result and, after it, the input.
// Reset clears the text count, the built flag, the output register and
// sets the alphabet limit to 256; the stores are not cleared.
module suffix_array_lcp_builder #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // func[1:0], symbol[9:2], index[20:10]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], suffix_start[12:2],
                                  // common_prefix[22:13], text_length[33:23]
);
  import sal_pkg::*;

  sal_cmd_t          cmd;
  sal_stat_t         stat;
  logic [ALIM_W-1:0] alim;
  logic [STS_W-1:0]  o_sts;
  logic [IDX_W-1:0]  o_start, o_len;
  logic [LCP_W-1:0]  o_lcp;

  sal_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready), .alim(alim)
  );

  sal_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .stat(stat), .cmd(cmd)
  );

  sal_dp #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .alim(alim),
    .in_valid(in_tvalid),
    .in_func(in_tdata[1:0]), .in_symbol(in_tdata[9:2]), .in_index(in_tdata[20:10]),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(o_sts), .out_start(o_start), .out_lcp(o_lcp), .out_length(o_len)
  );

  assign in_tready = cmd.in_ready;
  assign out_tdata = {6'b0, o_len, o_lcp, o_start, o_sts};

endmodule

/* rtl/sal_cfg.sv */
module sal_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [2:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready,
  output logic [sal_pkg::ALIM_W-1:0] alim
);
  import sal_pkg::*;

  logic [ALIM_W-1:0] alim_r;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alim_r <= ALIM_RESET;
    end else if (wr_en && cfg_paddr[2] == REG_ALIM) begin
      alim_r <= cfg_pwdata[ALIM_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_ALIM) begin
      cfg_prdata = {{(32-ALIM_W){1'b0}}, alim_r};
    end
  end

  assign alim = alim_r;

endmodule

/* rtl/sal_ctrl.sv */
module sal_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  sal_pkg::sal_stat_t stat,
  output sal_pkg::sal_cmd_t  cmd
);
  import sal_pkg::*;

  sal_op_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= OP_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      OP_IDLE: begin
        if (stat.build_go) state_nxt = OP_INIT_RD;
        else if (stat.rd_go) state_nxt = OP_RDWAIT;
      end
      OP_RDWAIT:  state_nxt = OP_IDLE;
      OP_INIT_RD: state_nxt = stat.i_lt_n ? OP_INIT_WR : OP_YA;
      OP_INIT_WR: state_nxt = OP_INIT_RD;
      OP_YA:      state_nxt = stat.i_lt_j ? OP_YA : OP_YB_RD;
      OP_YB_RD:   state_nxt = stat.i_lt_n ? OP_YB_WR : OP_CLR;
      OP_YB_WR:   state_nxt = OP_YB_RD;
      OP_CLR:     state_nxt = stat.i_last_ts ? OP_H_RDX : OP_CLR;
      OP_H_RDX:   state_nxt = stat.i_lt_n ? OP_H_RDC : OP_P_RD;
      OP_H_RDC:   state_nxt = OP_H_WR;
      OP_H_WR:    state_nxt = OP_H_RDX;
      OP_P_RD:    state_nxt = OP_P_WR;
      OP_P_WR:    state_nxt = stat.i_last_ts ? OP_S_RDY : OP_P_RD;
      OP_S_RDY:   state_nxt = OP_S_RDX;
      OP_S_RDX:   state_nxt = OP_S_RDC;
      OP_S_RDC:   state_nxt = OP_S_WR;
      OP_S_WR:    state_nxt = stat.i_zero ? OP_R_RD0 : OP_S_RDY;
      OP_R_RD0:   state_nxt = OP_R_WR0;
      OP_R_WR0:   state_nxt = OP_C_RDS;
      OP_C_RDS: begin
        if (stat.i_lt_n) state_nxt = OP_C_RDA;
        else if (stat.p_eq_n) state_nxt = OP_F_RD;
        else state_nxt = OP_YA;
      end
      OP_C_RDA:   state_nxt = OP_C_RDB;
      OP_C_RDB:   state_nxt = OP_C_RDAJ;
      OP_C_RDAJ:  state_nxt = OP_C_RDBJ;
      OP_C_RDBJ:  state_nxt = OP_C_WR;
      OP_C_WR:    state_nxt = OP_C_RDS;
      OP_F_RD:    state_nxt = stat.i_lt_n ? OP_F_WR : OP_L_START;
      OP_F_WR:    state_nxt = OP_F_RD;
      OP_L_START: state_nxt = OP_L_RDR;
      OP_L_RDR:   state_nxt = stat.i1_lt_n ? OP_L_RDS : OP_DONE;
      OP_L_RDS:   state_nxt = stat.rank_zero ? OP_L_RDR : OP_L_RDT1;
      OP_L_RDT1:  state_nxt = OP_L_RDT2;
      OP_L_RDT2:  state_nxt = OP_L_CMP;
      OP_L_CMP:   state_nxt = stat.match ? OP_L_RDT1 : OP_L_RDR;
      OP_DONE:    state_nxt = OP_IDLE;
      default:    state_nxt = OP_IDLE;
    endcase
  end

  assign cmd.op       = state_r;
  assign cmd.in_ready = (state_r == OP_IDLE) && stat.out_free;

endmodule

/* rtl/sal_dp.sv */
module sal_dp #(
  parameter int MAX_TEXT = 1024,
  parameter int ALPHABET = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sal_pkg::sal_cmd_t          cmd,
  output sal_pkg::sal_stat_t         stat,
  input  logic [sal_pkg::ALIM_W-1:0] alim,
  input  logic                       in_valid,
  input  logic [sal_pkg::FUNC_W-1:0] in_func,
  input  logic [sal_pkg::SYM_W-1:0]  in_symbol,
  input  logic [sal_pkg::IDX_W-1:0]  in_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [sal_pkg::STS_W-1:0]  out_status,
  output logic [sal_pkg::IDX_W-1:0]  out_start,
  output logic [sal_pkg::LCP_W-1:0]  out_lcp,
  output logic [sal_pkg::IDX_W-1:0]  out_length
);
  import sal_pkg::*;

  localparam int SEQ_LEN = MAX_TEXT + 1;
  localparam int TA      = (SEQ_LEN > ALPHABET) ? SEQ_LEN : ALPHABET;
  localparam int TS      = (TA > 256) ? TA : 256;
  localparam int PW      = $clog2(MAX_TEXT + 2);
  localparam int AW      = $clog2(SEQ_LEN);
  localparam int TW      = $clog2(MAX_TEXT);
  localparam int CW      = $clog2(TS);
  localparam int IW      = $clog2(TS + 1);

  logic [SYM_W-1:0] txt_mem [MAX_TEXT];
  logic [PW-1:0]    sa_mem  [SEQ_LEN];
  logic [PW-1:0]    rk0_mem [SEQ_LEN];
  logic [PW-1:0]    rk1_mem [SEQ_LEN];
  logic [PW-1:0]    lcp_mem [SEQ_LEN];
  logic [PW-1:0]    cnt_mem [TS];

  logic [SYM_W-1:0] txt_q;
  logic [PW-1:0]    sa_q, rk0_q, rk1_q, lcp_q, cnt_q;

  logic txt_re, txt_we, sa_re, sa_we, lcp_re, lcp_we, cnt_re, cnt_we;
  logic xr_re, xw_we, yr_re, yw_we;
  logic rk0_re, rk0_we, rk1_re, rk1_we;
  logic [TW-1:0]    txt_ra, txt_wa;
  logic [SYM_W-1:0] txt_wd;
  logic [AW-1:0]    sa_ra, sa_wa, lcp_ra, lcp_wa, xr_ra, xw_wa, yr_ra, yw_wa;
  logic [AW-1:0]    rk0_ra, rk0_wa, rk1_ra, rk1_wa;
  logic [PW-1:0]    sa_wd, lcp_wd, xw_wd, yw_wd, rk0_wd, rk1_wd, cnt_wd;
  logic [CW-1:0]    cnt_ra, cnt_wa;

  logic [PW-1:0] tc_r, tc_nxt, n_r, n_nxt, j_r, j_nxt, p_r, p_nxt, k_r, k_nxt;
  logic [PW-1:0] a_r, a_nxt, b_r, b_nxt, r_r, r_nxt, o_r, o_nxt, acc_r, acc_nxt;
  logic [PW-1:0] ya_r, ya_nxt, yb_r, yb_nxt, yaj_r, yaj_nxt;
  logic [SYM_W-1:0] t1_r, t1_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic xsel_r, xsel_nxt, built_r, built_nxt;

  logic              out_valid_r, out_load;
  logic [STS_W-1:0]  out_sts_r, ld_sts;
  logic [PW-1:0]     out_sa_r, out_lcp_r, ld_sa, ld_lcp;
  logic [PW-1:0]     out_tl_r;

  logic [PW-1:0] x_q, y_q;
  logic [PW:0]   aj, bj, ik, ok_sum;
  logic          take, rd_bad, same, match;

  assign x_q = xsel_r ? rk1_q : rk0_q;
  assign y_q = xsel_r ? rk0_q : rk1_q;
  assign take = in_valid && cmd.in_ready;
  assign rd_bad = !built_r || (in_index > tc_r);
  assign aj = {1'b0, a_r} + {1'b0, j_r};
  assign bj = {1'b0, b_r} + {1'b0, j_r};
  assign ik = {1'b0, PW'(i_r)} + {1'b0, k_r};
  assign ok_sum = {1'b0, o_r} + {1'b0, k_r};
  assign same = (ya_r == yb_r) && (aj < n_r) && (bj < n_r) && (yaj_r == y_q);
  assign match = (ik < tc_r) && (ok_sum < tc_r) && (t1_r == txt_q);

  assign stat.i_lt_n    = i_r < n_r;
  assign stat.i_lt_j    = i_r < j_r;
  assign stat.i_last_ts = i_r == IW'(TS - 1);
  assign stat.i_zero    = i_r == '0;
  assign stat.p_eq_n    = p_r == n_r;
  assign stat.rank_zero = x_q == '0;
  assign stat.match     = match;
  assign stat.i1_lt_n   = (i_r + 1'b1) < n_r;
  assign stat.rd_go     = take && in_func == FUNC_READ && !rd_bad;
  assign stat.build_go  = take && in_func == FUNC_BUILD;
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    txt_re = 1'b0; txt_ra = '0; txt_we = 1'b0; txt_wa = '0; txt_wd = '0;
    sa_re = 1'b0;  sa_ra = '0;  sa_we = 1'b0;  sa_wa = '0;  sa_wd = '0;
    lcp_re = 1'b0; lcp_ra = '0; lcp_we = 1'b0; lcp_wa = '0; lcp_wd = '0;
    cnt_re = 1'b0; cnt_ra = '0; cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0;
    xr_re = 1'b0;  xr_ra = '0;  xw_we = 1'b0;  xw_wa = '0;  xw_wd = '0;
    yr_re = 1'b0;  yr_ra = '0;  yw_we = 1'b0;  yw_wa = '0;  yw_wd = '0;
    tc_nxt = tc_r; n_nxt = n_r; j_nxt = j_r; p_nxt = p_r; k_nxt = k_r;
    a_nxt = a_r; b_nxt = b_r; r_nxt = r_r; o_nxt = o_r; acc_nxt = acc_r;
    ya_nxt = ya_r; yb_nxt = yb_r; yaj_nxt = yaj_r; t1_nxt = t1_r;
    i_nxt = i_r; xsel_nxt = xsel_r; built_nxt = built_r;
    out_load = 1'b0; ld_sts = STS_OK; ld_sa = '0; ld_lcp = '0;
    case (cmd.op)
      OP_IDLE: begin
        if (take) begin
          case (in_func)
            FUNC_APPEND: begin
              out_load = 1'b1;
              if (in_symbol == '0 || {1'b0, in_symbol} >= alim) begin
                ld_sts = STS_BAD_SYM;
              end else if (tc_r == PW'(MAX_TEXT)) begin
                ld_sts = STS_FULL;
              end else begin
                txt_we = 1'b1;
                txt_wa = tc_r[TW-1:0];
                txt_wd = in_symbol;
                tc_nxt = tc_r + 1'b1;
                built_nxt = 1'b0;
              end
            end
            FUNC_BUILD: begin
              n_nxt = tc_r + 1'b1;
              i_nxt = '0;
              j_nxt = '0;
              xsel_nxt = 1'b0;
            end
            FUNC_READ: begin
              if (rd_bad) begin
                out_load = 1'b1;
                ld_sts = STS_BAD_IDX;
              end else begin
                sa_re = 1'b1;
                sa_ra = AW'(in_index);
                lcp_re = 1'b1;
                lcp_ra = AW'(in_index);
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      OP_RDWAIT: begin
        out_load = 1'b1;
        ld_sa = sa_q;
        ld_lcp = lcp_q;
      end
      OP_INIT_RD: begin
        if (i_r < n_r) begin
          txt_re = 1'b1;
          txt_ra = i_r[TW-1:0];
        end else begin
          i_nxt = '0;
        end
      end
      OP_INIT_WR: begin
        xw_we = 1'b1;
        xw_wa = i_r[AW-1:0];
        xw_wd = (i_r < tc_r) ? PW'(txt_q) : '0;
        sa_we = 1'b1;
        sa_wa = i_r[AW-1:0];
        sa_wd = PW'(i_r);
        i_nxt = i_r + 1'b1;
      end
      OP_YA: begin
        // suffixes whose second half runs past the end come first
        if (i_r < j_r) begin
          yw_we = 1'b1;
          yw_wa = i_r[AW-1:0];
          yw_wd = n_r - j_r + PW'(i_r);
          i_nxt = i_r + 1'b1;
        end else begin
          i_nxt = '0;
          p_nxt = j_r;
        end
      end
      OP_YB_RD: begin
        if (i_r < n_r) begin
          sa_re = 1'b1;
          sa_ra = i_r[AW-1:0];
        end else begin
          i_nxt = '0;
        end
      end
      OP_YB_WR: begin
        if (sa_q >= j_r) begin
          yw_we = 1'b1;
          yw_wa = p_r[AW-1:0];
          yw_wd = sa_q - j_r;
          p_nxt = p_r + 1'b1;
        end
        i_nxt = i_r + 1'b1;
      end
      OP_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[CW-1:0];
        i_nxt = (i_r == IW'(TS - 1)) ? '0 : i_r + 1'b1;
      end
      OP_H_RDX: begin
        if (i_r < n_r) begin
          xr_re = 1'b1;
          xr_ra = i_r[AW-1:0];
        end else begin
          i_nxt = '0;
          acc_nxt = '0;
        end
      end
      OP_H_RDC: begin
        cnt_re = 1'b1;
        cnt_ra = CW'(x_q);
      end
      OP_H_WR: begin
        cnt_we = 1'b1;
        cnt_wa = CW'(x_q);
        cnt_wd = cnt_q + 1'b1;
        i_nxt = i_r + 1'b1;
      end
      OP_P_RD: begin
        cnt_re = 1'b1;
        cnt_ra = i_r[CW-1:0];
      end
      OP_P_WR: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[CW-1:0];
        cnt_wd = cnt_q + acc_r;
        acc_nxt = cnt_q + acc_r;
        i_nxt = (i_r == IW'(TS - 1)) ? IW'(n_r - 1'b1) : i_r + 1'b1;
      end
      OP_S_RDY: begin
        yr_re = 1'b1;
        yr_ra = i_r[AW-1:0];
      end
      OP_S_RDX: begin
        xr_re = 1'b1;
        xr_ra = AW'(y_q);
      end
      OP_S_RDC: begin
        cnt_re = 1'b1;
        cnt_ra = CW'(x_q);
      end
      OP_S_WR: begin
        cnt_we = 1'b1;
        cnt_wa = CW'(x_q);
        cnt_wd = cnt_q - 1'b1;
        sa_we = 1'b1;
        sa_wa = AW'(cnt_q - 1'b1);
        sa_wd = y_q;
        if (i_r == '0) begin
          xsel_nxt = !xsel_r;
        end else begin
          i_nxt = i_r - 1'b1;
        end
      end
      OP_R_RD0: begin
        sa_re = 1'b1;
        sa_ra = '0;
      end
      OP_R_WR0: begin
        xw_we = 1'b1;
        xw_wa = AW'(sa_q);
        a_nxt = sa_q;
        p_nxt = PW'(1);
        i_nxt = IW'(1);
      end
      OP_C_RDS: begin
        if (i_r < n_r) begin
          sa_re = 1'b1;
          sa_ra = i_r[AW-1:0];
        end else begin
          i_nxt = '0;
          if (p_r != n_r) begin
            j_nxt = (j_r == '0) ? PW'(1) : {j_r[PW-2:0], 1'b0};
          end
        end
      end
      OP_C_RDA: begin
        b_nxt = sa_q;
        yr_re = 1'b1;
        yr_ra = AW'(a_r);
      end
      OP_C_RDB: begin
        ya_nxt = y_q;
        yr_re = 1'b1;
        yr_ra = AW'(b_r);
      end
      OP_C_RDAJ: begin
        yb_nxt = y_q;
        yr_re = 1'b1;
        yr_ra = aj[AW-1:0];
      end
      OP_C_RDBJ: begin
        yaj_nxt = y_q;
        yr_re = 1'b1;
        yr_ra = bj[AW-1:0];
      end
      OP_C_WR: begin
        xw_we = 1'b1;
        xw_wa = AW'(b_r);
        if (same) begin
          xw_wd = p_r - 1'b1;
        end else begin
          xw_wd = p_r;
          p_nxt = p_r + 1'b1;
        end
        a_nxt = b_r;
        i_nxt = i_r + 1'b1;
      end
      OP_F_RD: begin
        if (i_r < n_r) begin
          sa_re = 1'b1;
          sa_ra = i_r[AW-1:0];
        end
      end
      OP_F_WR: begin
        xw_we = 1'b1;
        xw_wa = AW'(sa_q);
        xw_wd = PW'(i_r);
        i_nxt = i_r + 1'b1;
      end
      OP_L_START: begin
        lcp_we = 1'b1;
        lcp_wa = '0;
        k_nxt = '0;
        i_nxt = '0;
      end
      OP_L_RDR: begin
        xr_re = 1'b1;
        xr_ra = i_r[AW-1:0];
      end
      OP_L_RDS: begin
        r_nxt = x_q;
        if (k_r != '0) k_nxt = k_r - 1'b1;
        if (x_q == '0) begin
          k_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          sa_re = 1'b1;
          sa_ra = AW'(x_q - 1'b1);
        end
      end
      OP_L_RDT1: begin
        o_nxt = sa_q;
        txt_re = 1'b1;
        txt_ra = ik[TW-1:0];
      end
      OP_L_RDT2: begin
        t1_nxt = txt_q;
        txt_re = 1'b1;
        txt_ra = ok_sum[TW-1:0];
      end
      OP_L_CMP: begin
        if (match) begin
          k_nxt = k_r + 1'b1;
        end else begin
          lcp_we = 1'b1;
          lcp_wa = AW'(r_r);
          lcp_wd = k_r;
          i_nxt = i_r + 1'b1;
        end
      end
      OP_DONE: begin
        built_nxt = 1'b1;
        out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // map the current/previous rank roles onto the two physical stores
  always_comb begin
    rk0_re = xsel_r ? yr_re : xr_re;
    rk0_ra = xsel_r ? yr_ra : xr_ra;
    rk0_we = xsel_r ? yw_we : xw_we;
    rk0_wa = xsel_r ? yw_wa : xw_wa;
    rk0_wd = xsel_r ? yw_wd : xw_wd;
    rk1_re = xsel_r ? xr_re : yr_re;
    rk1_ra = xsel_r ? xr_ra : yr_ra;
    rk1_we = xsel_r ? xw_we : yw_we;
    rk1_wa = xsel_r ? xw_wa : yw_wa;
    rk1_wd = xsel_r ? xw_wd : yw_wd;
  end

  always_ff @(posedge clk) begin
    if (txt_we) txt_mem[txt_wa] <= txt_wd;
    if (txt_re) txt_q <= txt_mem[txt_ra];
  end

  always_ff @(posedge clk) begin
    if (sa_we) sa_mem[sa_wa] <= sa_wd;
    if (sa_re) sa_q <= sa_mem[sa_ra];
  end

  always_ff @(posedge clk) begin
    if (rk0_we) rk0_mem[rk0_wa] <= rk0_wd;
    if (rk0_re) rk0_q <= rk0_mem[rk0_ra];
  end

  always_ff @(posedge clk) begin
    if (rk1_we) rk1_mem[rk1_wa] <= rk1_wd;
    if (rk1_re) rk1_q <= rk1_mem[rk1_ra];
  end

  always_ff @(posedge clk) begin
    if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
    if (lcp_re) lcp_q <= lcp_mem[lcp_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= '0;
      built_r <= 1'b0;
      out_valid_r <= 1'b0;
      i_r <= '0;
      xsel_r <= 1'b0;
    end else begin
      tc_r <= tc_nxt;
      built_r <= built_nxt;
      i_r <= i_nxt;
      xsel_r <= xsel_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt; j_r <= j_nxt; p_r <= p_nxt; k_r <= k_nxt;
    a_r <= a_nxt; b_r <= b_nxt; r_r <= r_nxt; o_r <= o_nxt; acc_r <= acc_nxt;
    ya_r <= ya_nxt; yb_r <= yb_nxt; yaj_r <= yaj_nxt; t1_r <= t1_nxt;
    if (out_load) begin
      out_sts_r <= ld_sts;
      out_sa_r <= ld_sa;
      out_lcp_r <= ld_lcp;
      out_tl_r <= tc_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_sts_r;
  assign out_start  = IDX_W'(out_sa_r);
  assign out_lcp    = LCP_W'(out_lcp_r);
  assign out_length = IDX_W'(out_tl_r);

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r <= PW'(MAX_TEXT))
    else $error("text count beyond store depth");

  a_built_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> $past(cmd.op == OP_DONE))
    else $error("built flag set outside build completion");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.in_ready |-> (cmd.op == OP_IDLE && !(out_valid_r && !out_ready)))
    else $error("item accepted while busy");

endmodule

/* tb/suffix_array_lcp_builder_tb.sv */
module suffix_array_lcp_builder_tb;
  import sal_pkg::*;

  localparam int MAXT = 1024;
  localparam int SEQ  = MAXT + 1;
  localparam int TBL  = 1025;
  localparam int CYCLE_LIMIT = 8000000;
  localparam logic [2:0] ADDR_ALIM = 3'd0;
  localparam logic [2:0] ADDR_NONE = 3'd4;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [10:0]      suffix_start;
    logic [LCP_W-1:0] common_prefix;
    logic [10:0]      text_length;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // func[1:0], symbol[9:2], index[20:10]
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [39:0] out_tdata;       // status[1:0], suffix_start[12:2],
                                // common_prefix[22:13], text_length[33:23]

  suffix_array_lcp_builder u_top (.*);

  always #2 clk = ~clk;

  // predicted block state
  logic [ALIM_W-1:0] alim;
  logic [7:0]        text_sym [MAXT];
  int                text_cnt;
  bit                is_built;
  int                sorted_pos [SEQ];
  int                common_len [SEQ];
  int                rank_cur [SEQ];
  int                rank_prev [SEQ];
  int                second_key [SEQ];
  int                bucket [TBL];

  result_t pending_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  bit      idle_on = 1'b1;
  bit      hold_req = 1'b0;

  function automatic int sym_at(int p);
    return (p < text_cnt) ? int'(text_sym[p]) : 0;
  endfunction

  // prefix doubling with a stable counting sort, then Kasai for the LCPs
  function automatic void build_suffix_index();
    int n, i, j, p, k, v, b, a, r, o;
    bit same;
    n = text_cnt + 1;
    for (i = 0; i < n; i++) begin
      rank_cur[i] = sym_at(i);
      sorted_pos[i] = i;
    end
    j = 0;
    p = 0;
    while (p < n) begin
      p = 0;
      for (i = 0; i < j && i < n; i++) begin
        second_key[p] = n - j + i;
        p++;
      end
      for (i = 0; i < n; i++)
        if (sorted_pos[i] >= j && p < n) begin
          second_key[p] = sorted_pos[i] - j;
          p++;
        end
      for (i = 0; i < TBL; i++) bucket[i] = 0;
      for (i = 0; i < n; i++) bucket[rank_cur[i]]++;
      for (i = 1; i < TBL; i++) bucket[i] += bucket[i-1];
      for (i = n - 1; i >= 0; i--) begin
        v = second_key[i];
        b = rank_cur[v];
        bucket[b]--;
        sorted_pos[bucket[b]] = v;
      end
      for (i = 0; i < n; i++) rank_prev[i] = rank_cur[i];
      p = 1;
      rank_cur[sorted_pos[0]] = 0;
      for (i = 1; i < n; i++) begin
        a = sorted_pos[i-1];
        b = sorted_pos[i];
        same = (rank_prev[a] == rank_prev[b]) && (a + j < n) && (b + j < n);
        if (same) same = (rank_prev[a+j] == rank_prev[b+j]);
        if (same) rank_cur[b] = p - 1;
        else begin
          rank_cur[b] = p;
          p++;
        end
      end
      j = (j == 0) ? 1 : j * 2;
    end
    for (i = 0; i < n; i++) rank_cur[sorted_pos[i]] = i;
    common_len[0] = 0;
    k = 0;
    for (i = 0; i + 1 < n; i++) begin
      r = rank_cur[i];
      if (k > 0) k--;
      if (r == 0) begin
        k = 0;
        continue;
      end
      o = sorted_pos[r-1];
      while (i + k < n && o + k < n && sym_at(i + k) == sym_at(o + k) && sym_at(i + k) != 0)
        k++;
      common_len[r] = k;
    end
    is_built = 1'b1;
  endfunction

  function automatic result_t predict_step(logic [1:0] func, logic [7:0] symbol,
                                           logic [10:0] index);
    result_t res;
    res = '0;
    if (func == FUNC_APPEND) begin
      if (symbol == 0 || symbol >= alim) res.status = STS_BAD_SYM;
      else if (text_cnt >= MAXT) res.status = STS_FULL;
      else begin
        text_sym[text_cnt] = symbol;
        text_cnt++;
        is_built = 1'b0;
      end
    end else if (func == FUNC_BUILD) begin
      build_suffix_index();
    end else if (func == FUNC_READ) begin
      if (!is_built || index > text_cnt) res.status = STS_BAD_IDX;
      else begin
        res.suffix_start = 11'(sorted_pos[index]);
        res.common_prefix = LCP_W'(common_len[index]);
      end
    end
    res.text_length = 11'(text_cnt);
    return res;
  endfunction

  task automatic send_item(logic [1:0] func, logic [7:0] symbol, logic [10:0] index);
    bit ok;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, index, symbol, func};
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    pending_results = {pending_results, predict_step(func, symbol, index)};
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_alim_reg(logic [2:0] addr, logic [31:0] value);
    drain_results();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_ALIM) alim = value[ALIM_W-1:0];
    // read back register 0
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr <= ADDR_ALIM;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata[ALIM_W-1:0] !== alim) begin
      $error("alphabet_limit: expected %0d, got %0d", alim, cfg_prdata[ALIM_W-1:0]);
      fail_count++;
    end
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_symbol();
    if ($urandom_range(0, 9) == 0)
      return (alim <= 255 && $urandom_range(0, 1)) ? 8'($urandom_range(alim, 255)) : 8'd0;
    return 8'($urandom_range(1, alim - 1));
  endfunction

  task automatic read_random(int count);
    for (int i = 0; i < count; i++)
      send_item(FUNC_READ, 8'($urandom), ($urandom_range(0, 19) == 0) ?
                11'($urandom) : 11'($urandom_range(0, text_cnt + 1)));
  endtask

  task automatic test_empty_and_errors();
    send_item(FUNC_READ, 8'd0, 11'd0);       // read before any build
    send_item(FUNC_BUILD, 8'hFF, 11'h7FF);   // build on an empty text
    send_item(FUNC_READ, 8'd0, 11'd0);
    send_item(FUNC_READ, 8'd0, 11'd1);
    send_item(FUNC_UNUSED, 8'hAA, 11'h555);
    send_item(FUNC_APPEND, 8'd0, 11'd0);
    send_item(FUNC_APPEND, 8'd255, 11'h7FF);
    send_item(FUNC_READ, 8'd0, 11'd0);       // append cleared the built state
    send_item(FUNC_APPEND, 8'd1, 11'd0);
    send_item(FUNC_APPEND, 8'd255, 11'd0);
    send_item(FUNC_BUILD, 8'd0, 11'd0);
    for (int i = 0; i <= 4; i++) send_item(FUNC_READ, 8'd0, 11'(i));
  endtask

  task automatic test_alphabet_limit();
    write_alim_reg(ADDR_ALIM, 32'd2);
    send_item(FUNC_APPEND, 8'd1, 11'd0);
    send_item(FUNC_APPEND, 8'd2, 11'd0);
    send_item(FUNC_APPEND, 8'd128, 11'd0);
    write_alim_reg(ADDR_NONE, 32'd9);        // no register at this address
    send_item(FUNC_APPEND, 8'd1, 11'd0);
    send_item(FUNC_APPEND, 8'd3, 11'd0);
    send_item(FUNC_BUILD, 8'd0, 11'd0);
    for (int i = 0; i <= 6; i++) send_item(FUNC_READ, 8'd0, 11'(i));
    write_alim_reg(ADDR_ALIM, 32'd256);
  endtask

  task automatic test_random_texts();
    int sizes [8] = '{10, 24, 50, 90, 150, 230, 330, 440};
    int limits [5] = '{2, 3, 5, 17, 256};
    for (int r = 0; r < 8; r++) begin
      write_alim_reg(ADDR_ALIM, 32'(limits[$urandom_range(0, 4)]));
      while (text_cnt < sizes[r]) send_item(FUNC_APPEND, rand_symbol(), 11'($urandom));
      if ($urandom_range(0, 1)) send_item(FUNC_UNUSED, 8'($urandom), 11'($urandom));
      send_item(FUNC_BUILD, 8'($urandom), 11'($urandom));
      read_random(45);
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_item(FUNC_APPEND, rand_symbol(), 11'd0);
    read_random(4);
    // stop offering until every result is back
    drain_results();
    send_item(FUNC_BUILD, 8'd0, 11'd0);
    read_random(20);
  endtask

  task automatic test_full_store();
    idle_on = 1'b0;
    write_alim_reg(ADDR_ALIM, 32'd256);
    while (text_cnt < MAXT)
      send_item(FUNC_APPEND, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                8'($urandom_range(1, 3)), 11'd0);
    send_item(FUNC_APPEND, 8'd7, 11'd0);     // dropped: store full
    send_item(FUNC_APPEND, 8'd0, 11'd0);     // symbol check wins over full
    send_item(FUNC_BUILD, 8'd0, 11'd0);
    send_item(FUNC_READ, 8'd0, 11'd1024);
    send_item(FUNC_READ, 8'd0, 11'd1025);
    send_item(FUNC_READ, 8'd0, 11'h7FF);
    send_item(FUNC_READ, 8'd0, 11'd0);
    read_random(60);
  endtask

  initial begin
    alim = ALIM_RESET;
    text_cnt = 0;
    is_built = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_errors();
    test_alphabet_limit();
    test_random_texts();
    test_backpressure();
    test_full_store();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // receiver: random stall bursts, and one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    result_t want, got;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[12:2], out_tdata[22:13], out_tdata[33:23]};
        if (pending_results.size() == 0) begin
          $error("result item with nothing pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.suffix_start !== want.suffix_start) begin
            $error("suffix_start: expected %0d, got %0d", want.suffix_start,
                   got.suffix_start);
            fail_count++;
          end
          if (got.common_prefix !== want.common_prefix) begin
            $error("common_prefix: expected %0d, got %0d", want.common_prefix,
                   got.common_prefix);
            fail_count++;
          end
          if (got.text_length !== want.text_length) begin
            $error("text_length: expected %0d, got %0d", want.text_length,
                   got.text_length);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/sal_pkg.sv
rtl/sal_cfg.sv
rtl/sal_ctrl.sv
rtl/sal_dp.sv
rtl/suffix_array_lcp_builder.sv
tb/suffix_array_lcp_builder_tb.sv
